### rtl/core/icl_pkg.sv
// Shared constants for the ichimoku cloud line block.
package icl_pkg;
   localparam int MAX_WINDOW_DEF       = 64;
   localparam int MAX_DISPLACEMENT_DEF = 64;
   localparam int PRICE_BITS_DEF       = 32;

   localparam int IN_PRICE_W = 32;
   localparam int LINE_W     = 34;
   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 8;

   localparam logic [CSR_IDX_W-1:0] REG_CONVERSION_WINDOW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_WINDOW       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPAN_B_WINDOW     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DISPLACEMENT      = 8'd3;

   localparam logic [CFG_W-1:0] CONVERSION_RESET = 7'd9;
   localparam logic [CFG_W-1:0] BASE_RESET       = 7'd26;
   localparam logic [CFG_W-1:0] SPAN_B_RESET     = 7'd52;
   localparam logic [CFG_W-1:0] DISP_RESET       = 7'd26;
endpackage

### rtl/core/icl_cell.sv
// One storage cell of a shift/rotate chain.
module icl_cell #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             rotate_en,
   input  logic [WIDTH-1:0] from_prev,
   input  logic [WIDTH-1:0] from_next,
   output logic [WIDTH-1:0] data_q
);
   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // shift toward the tail on a new request, rotate toward the head while scanning
   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = from_prev;
      end else if (rotate_en) begin
         data_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;
endmodule

### rtl/core/ichimoku_cloud_lines.sv
// Top level: ichimoku conversion, base and leading span lines over a cell chain.
// One request is handled at a time. The candle history and the span delay chain
// (which carries both leading spans) are chains of cells that are rotated once
// around during a scan, so the head cell presents each stored entry in turn to the
// max/min and tap logic. After the scan the midpoints are formed and registered,
// and then the output register is loaded. A result waits in that register; the
// next request is taken as soon as the scan hardware is free, and its result
// stalls until the waiting one is taken. Line values are in quarter ticks and are
// zero when not valid.
module ichimoku_cloud_lines #(
   parameter int MAX_WINDOW       = icl_pkg::MAX_WINDOW_DEF,
   parameter int MAX_DISPLACEMENT = icl_pkg::MAX_DISPLACEMENT_DEF,
   parameter int PRICE_BITS       = icl_pkg::PRICE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [icl_pkg::IN_PRICE_W-1:0] req_high_price,
   input  logic [icl_pkg::IN_PRICE_W-1:0] req_low_price,
   input  logic [icl_pkg::IN_PRICE_W-1:0] req_close_price,
   input  logic                          req_first_of_series,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [icl_pkg::LINE_W-1:0]     rsp_conversion_line,
   output logic                          rsp_conversion_valid,
   output logic [icl_pkg::LINE_W-1:0]     rsp_base_line,
   output logic                          rsp_base_valid,
   output logic [icl_pkg::LINE_W-1:0]     rsp_leading_span_one,
   output logic                          rsp_leading_span_one_valid,
   output logic [icl_pkg::LINE_W-1:0]     rsp_leading_span_two,
   output logic                          rsp_leading_span_two_valid,
   output logic [icl_pkg::IN_PRICE_W-1:0] rsp_close_out,
   input  logic                          csr_we,
   input  logic [icl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [icl_pkg::CFG_W-1:0]      csr_wdata
);
   localparam int P      = PRICE_BITS;
   localparam int LF     = P + 2;
   localparam int DW     = 2 * (LF + 1);
   localparam int SCAN_L = (MAX_WINDOW > MAX_DISPLACEMENT) ? MAX_WINDOW : MAX_DISPLACEMENT;
   localparam int KW     = $clog2(SCAN_L);
   localparam int CNT_CAP = 2 * SCAN_L;
   localparam int CW     = $clog2(CNT_CAP + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_MID  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // configuration
   logic [icl_pkg::CFG_W-1:0] conv_w_ff, base_w_ff, spanb_w_ff, disp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         conv_w_ff  <= icl_pkg::CONVERSION_RESET;
         base_w_ff  <= icl_pkg::BASE_RESET;
         spanb_w_ff <= icl_pkg::SPAN_B_RESET;
         disp_ff    <= icl_pkg::DISP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            icl_pkg::REG_CONVERSION_WINDOW: conv_w_ff  <= csr_wdata;
            icl_pkg::REG_BASE_WINDOW:       base_w_ff  <= csr_wdata;
            icl_pkg::REG_SPAN_B_WINDOW:     spanb_w_ff <= csr_wdata;
            icl_pkg::REG_DISPLACEMENT:      disp_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [1:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic          accept;
   logic          scanning;
   logic          hist_rot, dly_rot, dly_push;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign scanning  = (state_ff == ST_SCAN);
   assign hist_rot  = scanning && (32'(k_ff) < MAX_WINDOW);
   assign dly_rot   = scanning && (32'(k_ff) < MAX_DISPLACEMENT);

   // candle history chain: {high, low}
   logic [2*P-1:0] hist_q [MAX_WINDOW];
   logic [2*P-1:0] new_candle;
   assign new_candle = {P'(req_high_price), P'(req_low_price)};

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_hist
      icl_cell #(.WIDTH(2 * P)) u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .rotate_en (hist_rot),
         .from_prev ((i == 0) ? new_candle : hist_q[(i == 0) ? 0 : i - 1]),
         .from_next (hist_q[(i + 1) % MAX_WINDOW]),
         .data_q    (hist_q[i])
      );
   end

   // span delay chain: {span one valid, value, span two valid, value}
   logic [DW-1:0] dly_q [MAX_DISPLACEMENT];
   logic [DW-1:0] dly_new;

   for (genvar i = 0; i < MAX_DISPLACEMENT; i++) begin : g_dly
      icl_cell #(.WIDTH(DW)) u_cell (
         .clock     (clock),
         .shift_en  (dly_push),
         .rotate_en (dly_rot),
         .from_prev ((i == 0) ? dly_new : dly_q[(i == 0) ? 0 : i - 1]),
         .from_next (dly_q[(i + 1) % MAX_DISPLACEMENT]),
         .data_q    (dly_q[i])
      );
   end

   // series length
   logic [CW-1:0] count_ff, cur_ff;
   logic [CW:0]   filled;
   logic [CW-1:0] cnt_base;
   assign cnt_base = req_first_of_series ? '0 : count_ff;
   assign filled   = {1'b0, cur_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         if (32'(cnt_base) + 1 > CNT_CAP) begin
            count_ff <= CW'(CNT_CAP);
         end else begin
            count_ff <= cnt_base + 1'b1;
         end
      end
   end

   // per-request payload
   logic [icl_pkg::IN_PRICE_W-1:0] close_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         close_ff <= req_close_price;
         cur_ff   <= cnt_base;
      end
   end

   // scan accumulators
   logic [P-1:0] cur_hi, cur_lo;
   logic [P-1:0] cmx_ff, cmn_ff, bmx_ff, bmn_ff, smx_ff, smn_ff;
   logic [DW-1:0] tap_ff;
   assign cur_hi = hist_q[0][2*P-1:P];
   assign cur_lo = hist_q[0][P-1:0];

   always_ff @(posedge clock) begin
      if (scanning) begin
         if (k_ff == '0) begin
            cmx_ff <= cur_hi; bmx_ff <= cur_hi; smx_ff <= cur_hi;
            cmn_ff <= cur_lo; bmn_ff <= cur_lo; smn_ff <= cur_lo;
         end else begin
            if (32'(k_ff) < 32'(conv_w_ff)) begin
               if (cur_hi > cmx_ff) cmx_ff <= cur_hi;
               if (cur_lo < cmn_ff) cmn_ff <= cur_lo;
            end
            if (32'(k_ff) < 32'(base_w_ff)) begin
               if (cur_hi > bmx_ff) bmx_ff <= cur_hi;
               if (cur_lo < bmn_ff) bmn_ff <= cur_lo;
            end
            if (32'(k_ff) < 32'(spanb_w_ff)) begin
               if (cur_hi > smx_ff) smx_ff <= cur_hi;
               if (cur_lo < smn_ff) smn_ff <= cur_lo;
            end
         end
         if (32'(k_ff) + 1 == 32'(disp_ff)) begin
            tap_ff <= dly_q[0];
         end
      end
   end

   // window validity
   function automatic logic win_ok(input logic [icl_pkg::CFG_W-1:0] w,
                                   input logic [CW:0] n);
      win_ok = (w != '0) && (32'(w) <= MAX_WINDOW) && (32'(n) >= 32'(w));
   endfunction

   // midpoints
   logic [LF-1:0] cq_ff, bq_ff, sq_ff;
   logic          cv_ff, bv_ff, sv_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_MID) begin
         cq_ff <= {({1'b0, cmx_ff} + {1'b0, cmn_ff}), 1'b0};
         bq_ff <= {({1'b0, bmx_ff} + {1'b0, bmn_ff}), 1'b0};
         sq_ff <= {({1'b0, smx_ff} + {1'b0, smn_ff}), 1'b0};
         cv_ff <= win_ok(conv_w_ff, filled);
         bv_ff <= win_ok(base_w_ff, filled);
         sv_ff <= win_ok(spanb_w_ff, filled);
      end
   end

   // leading spans
   logic [LF:0]   one_sum;
   logic [LF-1:0] one_val;
   logic          one_v, two_v;
   logic [DW-1:0] span_out;
   logic          tap_ok;
   assign one_sum = {1'b0, cq_ff} + {1'b0, bq_ff};
   assign one_val = one_sum[LF:1];
   assign one_v   = cv_ff && bv_ff;
   assign two_v   = sv_ff;
   assign dly_new = {one_v, one_v ? one_val : LF'(0), two_v, two_v ? sq_ff : LF'(0)};
   assign tap_ok  = (32'(disp_ff) <= MAX_DISPLACEMENT) && (32'(cur_ff) >= 32'(disp_ff));

   always_comb begin
      if (disp_ff == '0) begin
         span_out = dly_new;
      end else if (tap_ok) begin
         span_out = tap_ff;
      end else begin
         span_out = '0;
      end
   end

   logic out_free;
   assign out_free = !rsp_valid || rsp_ready;
   assign dly_push = (state_ff == ST_DONE) && out_free;

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            k_in = k_ff + 1'b1;
            if (32'(k_ff) == SCAN_L - 1) begin
               state_in = ST_MID;
               k_in     = '0;
            end
         end
         ST_MID:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dly_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dly_push) begin
         rsp_conversion_line        <= cv_ff ? icl_pkg::LINE_W'(cq_ff) : '0;
         rsp_conversion_valid       <= cv_ff;
         rsp_base_line              <= bv_ff ? icl_pkg::LINE_W'(bq_ff) : '0;
         rsp_base_valid             <= bv_ff;
         rsp_leading_span_one_valid <= span_out[DW-1];
         rsp_leading_span_one       <= span_out[DW-1] ?
                                       icl_pkg::LINE_W'(span_out[DW-2:LF+1]) : '0;
         rsp_leading_span_two_valid <= span_out[LF];
         rsp_leading_span_two       <= span_out[LF] ?
                                       icl_pkg::LINE_W'(span_out[LF-1:0]) : '0;
         rsp_close_out              <= close_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### verif/ichimoku_cloud_lines_checker.sv
// Checker for the ichimoku cloud lines: tracks config, predicts each result, compares.
module ichimoku_cloud_lines_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [icl_pkg::IN_PRICE_W-1:0]  req_high_price,
   input  logic [icl_pkg::IN_PRICE_W-1:0]  req_low_price,
   input  logic [icl_pkg::IN_PRICE_W-1:0]  req_close_price,
   input  logic                            req_first_of_series,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [icl_pkg::LINE_W-1:0]      rsp_conversion_line,
   input  logic                            rsp_conversion_valid,
   input  logic [icl_pkg::LINE_W-1:0]      rsp_base_line,
   input  logic                            rsp_base_valid,
   input  logic [icl_pkg::LINE_W-1:0]      rsp_leading_span_one,
   input  logic                            rsp_leading_span_one_valid,
   input  logic [icl_pkg::LINE_W-1:0]      rsp_leading_span_two,
   input  logic                            rsp_leading_span_two_valid,
   input  logic [icl_pkg::IN_PRICE_W-1:0]  rsp_close_out,
   input  logic                            csr_we,
   input  logic [icl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [icl_pkg::CFG_W-1:0]       csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              line_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = icl_pkg::MAX_WINDOW_DEF;
   localparam int DISP_MAX  = icl_pkg::MAX_DISPLACEMENT_DEF;
   localparam int COUNT_TOP = 2 * ((DEPTH > DISP_MAX) ? DEPTH : DISP_MAX);
   localparam int LW        = icl_pkg::LINE_W;
   localparam int PW        = icl_pkg::IN_PRICE_W;

   typedef struct packed {
      logic [LW-1:0]  conversion_line;
      logic           conversion_valid;
      logic [LW-1:0]  base_line;
      logic           base_valid;
      logic [LW-1:0]  span_one;
      logic           span_one_valid;
      logic [LW-1:0]  span_two;
      logic           span_two_valid;
      logic [PW-1:0]  close_out;
   } cloud_lines_type;

   logic [icl_pkg::CFG_W-1:0] conv_win, base_win, spanb_win, disp;
   logic [PW-1:0]         highs [DEPTH];
   logic [PW-1:0]         lows  [DEPTH];
   logic [LW:0]           span_one_line [DISP_MAX];
   logic [LW:0]           span_two_line [DISP_MAX];
   int                    candles;
   cloud_lines_type       expected_lines [$];

   assign pending_count = expected_lines.size();

   // Donchian midpoint in quarter ticks over the newest w candles
   function automatic logic midpoint(input int w, input int filled,
                                     output logic [LW-1:0] mid);
      logic [PW-1:0] mx, mn;
      mid = '0;
      if (w == 0 || w > DEPTH || filled < w) return 1'b0;
      mx = highs[0];
      mn = lows[0];
      for (int i = 1; i < w; i++) begin
         if (highs[i] > mx) mx = highs[i];
         if (lows[i] < mn) mn = lows[i];
      end
      mid = {({1'b0, mx} + {1'b0, mn}), 1'b0};
      return 1'b1;
   endfunction

   // advance the history by one candle and work out its result
   task automatic predict_lines(input logic [PW-1:0] hi, lo, cl, input logic first);
      cloud_lines_type       r;
      logic [LW-1:0]         cq, bq, sq;
      logic                  cv, bv, sv;
      logic [LW:0]           one_now, two_now, one_out, two_out;
      logic [LW:0]           sum;
      int                    filled;
      if (first) candles = 0;
      for (int i = DEPTH - 1; i > 0; i--) begin
         highs[i] = highs[i-1];
         lows[i]  = lows[i-1];
      end
      highs[0] = hi;
      lows[0]  = lo;
      filled = candles + 1;
      cv = midpoint(int'(conv_win), filled, cq);
      bv = midpoint(int'(base_win), filled, bq);
      sv = midpoint(int'(spanb_win), filled, sq);
      sum = {1'b0, cq} + {1'b0, bq};
      one_now = (cv && bv) ? {1'b1, sum[LW:1]} : '0;
      two_now = sv ? {1'b1, sq} : '0;
      if (disp == 0) begin
         one_out = one_now;
         two_out = two_now;
      end else if (int'(disp) <= DISP_MAX && candles >= int'(disp)) begin
         one_out = span_one_line[disp-1];
         two_out = span_two_line[disp-1];
      end else begin
         one_out = '0;
         two_out = '0;
      end
      for (int i = DISP_MAX - 1; i > 0; i--) begin
         span_one_line[i] = span_one_line[i-1];
         span_two_line[i] = span_two_line[i-1];
      end
      span_one_line[0] = one_now;
      span_two_line[0] = two_now;
      candles = (filled > COUNT_TOP) ? COUNT_TOP : filled;
      r.conversion_line  = cv ? cq : '0;
      r.conversion_valid = cv;
      r.base_line        = bv ? bq : '0;
      r.base_valid       = bv;
      r.span_one_valid   = one_out[LW];
      r.span_one         = one_out[LW] ? one_out[LW-1:0] : '0;
      r.span_two_valid   = two_out[LW];
      r.span_two         = two_out[LW] ? two_out[LW-1:0] : '0;
      r.close_out        = cl;
      expected_lines.insert(expected_lines.size(), r);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      cloud_lines_type e;
      if (reset) begin
         conv_win   = icl_pkg::CONVERSION_RESET;
         base_win   = icl_pkg::BASE_RESET;
         spanb_win  = icl_pkg::SPAN_B_RESET;
         disp       = icl_pkg::DISP_RESET;
         candles    = 0;
         fail_count = 0;
         line_count = 0;
         expected_lines.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               icl_pkg::REG_CONVERSION_WINDOW: conv_win  = csr_wdata;
               icl_pkg::REG_BASE_WINDOW:       base_win  = csr_wdata;
               icl_pkg::REG_SPAN_B_WINDOW:     spanb_win = csr_wdata;
               icl_pkg::REG_DISPLACEMENT:      disp      = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_lines(req_high_price, req_low_price, req_close_price, req_first_of_series);
         if (rsp_valid && rsp_ready) begin
            line_count++;
            if (expected_lines.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result, close %0h", $time, rsp_close_out);
            end else begin
               e = expected_lines[0];
               expected_lines.delete(0);
               check_field("conversion_line", 64'(e.conversion_line),
                           64'(rsp_conversion_line));
               check_field("conversion_valid", 64'(e.conversion_valid),
                           64'(rsp_conversion_valid));
               check_field("base_line", 64'(e.base_line), 64'(rsp_base_line));
               check_field("base_valid", 64'(e.base_valid), 64'(rsp_base_valid));
               check_field("leading_span_one", 64'(e.span_one), 64'(rsp_leading_span_one));
               check_field("leading_span_one_valid", 64'(e.span_one_valid),
                           64'(rsp_leading_span_one_valid));
               check_field("leading_span_two", 64'(e.span_two), 64'(rsp_leading_span_two));
               check_field("leading_span_two_valid", 64'(e.span_two_valid),
                           64'(rsp_leading_span_two_valid));
               check_field("close_out", 64'(e.close_out), 64'(rsp_close_out));
            end
         end
      end
   end
endmodule

### verif/ichimoku_cloud_lines_tb.sv
// Testbench top: drives candles and register settings, gives the verdict.
module ichimoku_cloud_lines_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int PW          = icl_pkg::IN_PRICE_W;
   localparam int CFW         = icl_pkg::CFG_W;

   logic                   clock, reset;
   logic                   req_valid, req_ready, req_first_of_series;
   logic [PW-1:0]          req_high_price, req_low_price, req_close_price;
   logic                   rsp_valid, rsp_ready;
   logic [icl_pkg::LINE_W-1:0] rsp_conversion_line, rsp_base_line;
   logic [icl_pkg::LINE_W-1:0] rsp_leading_span_one, rsp_leading_span_two;
   logic                   rsp_conversion_valid, rsp_base_valid;
   logic                   rsp_leading_span_one_valid, rsp_leading_span_two_valid;
   logic [PW-1:0]          rsp_close_out;
   logic                   csr_we;
   logic [icl_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CFW-1:0]         csr_wdata;
   int                     fail_count, pending_count, line_count;
   int                     send_idle_pct, recv_stall_pct, quiet_cycles, candles_sent;

   ichimoku_cloud_lines dut (.*);
   ichimoku_cloud_lines_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // watchdog over cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [PW-1:0] pick_price();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return $urandom_range(255);
         3: return 32'hFFFF_FF00 | $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   // one candle request, holding valid until accepted
   task automatic send_candle(input logic [PW-1:0] hi, lo, cl, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_high_price <= hi;
      req_low_price <= lo;
      req_close_price <= cl;
      req_first_of_series <= first;
      do @(posedge clock); while (!req_ready);
      candles_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // all four registers, written back to back while the block is idle
   task automatic write_windows(input logic [CFW-1:0] cw, bw, sw, dw);
      logic [CFW-1:0] vals [4];
      vals = '{cw, bw, sw, dw};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= icl_pkg::CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_series(input int count);
      logic first;
      for (int i = 0; i < count; i++) begin
         first = (i == 0) || ($urandom_range(149) == 0);
         send_candle(pick_price(), pick_price(), $urandom, first);
      end
   endtask

   initial begin
      logic [CFW-1:0] phase_cfg [8][4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_high_price = '0;
      req_low_price = '0;
      req_close_price = '0;
      req_first_of_series = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      candles_sent = 0;
      phase_cfg = '{'{7'd1, 7'd1, 7'd1, 7'd0}, '{7'd64, 7'd64, 7'd64, 7'd64},
                    '{7'd0, 7'd0, 7'd0, 7'd1}, '{7'd5, 7'd12, 7'd30, 7'd8},
                    '{7'd127, 7'd3, 7'd2, 7'd65}, '{7'd2, 7'd64, 7'd0, 7'd63},
                    '{7'd9, 7'd26, 7'd52, 7'd26}, '{7'd3, 7'd7, 7'd11, 7'd2}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, price extremes, series restarts
      send_candle('1, '0, '1, 1'b1);
      send_candle('0, '0, '0, 1'b0);
      send_candle('1, '1, 32'h8000_0000, 1'b0);
      for (int i = 0; i < 16; i++)
         send_candle(32'hFFFF_FFF0 + i, i, 32'h5555_5555 ^ i, 1'b0);
      send_candle(32'h1234, 32'h12, 32'hAAAA_AAAA, 1'b1);
      for (int i = 0; i < 4; i++)
         send_candle('1, '0, '0, i[0]);
      drain_results();

      // phases: eight fixed settings and four random ones, under four rotating idling mixes
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (p < 8)
            write_windows(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                          phase_cfg[p][3]);
         else
            write_windows(CFW'($urandom_range(64)), CFW'($urandom_range(64)),
                          CFW'($urandom_range(64)), CFW'($urandom_range(64)));
         random_series(150);
         drain_results();
      end

      $display("Sent %0d candles over 13 phases of window and displacement settings,",
               candles_sent);
      $display("and checked %0d results under mixed sender idling and receiver stalls.",
               line_count);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

### sim.f
rtl/core/icl_pkg.sv
rtl/core/icl_cell.sv
rtl/core/ichimoku_cloud_lines.sv
verif/ichimoku_cloud_lines_checker.sv
verif/ichimoku_cloud_lines_tb.sv
